// ===== src/vct_pkg.sv =====
package vct_pkg;

    // Timer register group selectors in the trap syndrome
    localparam logic [1:0] OP0_TIMER = 2'd3;
    localparam logic [3:0] CRN_TIMER = 4'd14;
    localparam logic [3:0] CRM_TIMER = 4'd2;

    // op2 codes of the three timer registers
    localparam logic [2:0] REG_TVAL = 3'd0;
    localparam logic [2:0] REG_CTL  = 3'd1;
    localparam logic [2:0] REG_CVAL = 3'd2;

    localparam logic [4:0] RT_ZR = 5'd31;

    localparam int DATA_W = 64;
    localparam int TVAL_W = 32;
    localparam int SYN_W  = 25;

    typedef struct packed {
        logic       fire;     // comparator fire event
        logic       hit;      // decoded as a timer register access
        logic       is_read;
        logic       rt_zr;    // rt is the zero register
        logic [2:0] reg_sel;  // op2
        logic [4:0] rt;
    } dec_t;

    typedef struct packed {
        logic              handled;
        logic              read_valid;
        logic [DATA_W-1:0] read_data;
        logic [4:0]        dest_reg;
        logic [DATA_W-1:0] cmp_deadline;
        logic              cmp_armed;
        logic              irq;
    } result_t;

endpackage

// ===== src/vct_decode.sv =====
module vct_decode
(
    input  logic                     kind,
    input  logic [vct_pkg::SYN_W-1:0] syndrome,
    output vct_pkg::dec_t            dec
);

    logic [1:0] op0;
    logic [3:0] crn;
    logic [3:0] crm;
    logic [2:0] op2;

    assign op0 = syndrome[21:20];
    assign crn = syndrome[13:10];
    assign crm = syndrome[4:1];
    assign op2 = syndrome[19:17];

    always_comb
    begin
        dec.fire    = kind;
        dec.is_read = syndrome[0];
        dec.rt      = syndrome[9:5];
        dec.rt_zr   = (syndrome[9:5] == vct_pkg::RT_ZR);
        dec.reg_sel = op2;
        // op2 above the compare register is not a timer register
        dec.hit     = !kind
                      && (op0 == vct_pkg::OP0_TIMER)
                      && (crn == vct_pkg::CRN_TIMER)
                      && (crm == vct_pkg::CRM_TIMER)
                      && ((op2 == vct_pkg::REG_TVAL)
                          || (op2 == vct_pkg::REG_CTL)
                          || (op2 == vct_pkg::REG_CVAL));
    end

endmodule

// ===== src/vct_exec.sv =====
module vct_exec
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  vct_pkg::dec_t              dec,
    input  logic [vct_pkg::DATA_W-1:0] write_data,
    input  logic [vct_pkg::DATA_W-1:0] count_now,
    output vct_pkg::result_t           res
);

    logic [vct_pkg::DATA_W-1:0] deadline_reg, deadline_next;
    logic                       enable_reg, enable_next;
    logic                       mask_reg, mask_next;
    logic [vct_pkg::DATA_W-1:0] bdl_reg, bdl_next;
    logic                       barmed_reg, barmed_next;

    logic [vct_pkg::DATA_W-1:0] src;
    logic [vct_pkg::DATA_W-1:0] tval_ext;
    logic [vct_pkg::DATA_W-1:0] remain;
    logic                       expired;
    logic [vct_pkg::DATA_W-1:0] rd_val;

    assign src      = dec.rt_zr ? '0 : write_data;
    assign tval_ext = {{(vct_pkg::DATA_W - vct_pkg::TVAL_W){src[vct_pkg::TVAL_W-1]}},
                       src[vct_pkg::TVAL_W-1:0]};
    assign remain   = deadline_reg - count_now;
    assign expired  = (count_now >= deadline_reg);

    always_comb
    begin
        case (dec.reg_sel)
            vct_pkg::REG_TVAL:
                rd_val = {{(vct_pkg::DATA_W - vct_pkg::TVAL_W){1'b0}},
                          remain[vct_pkg::TVAL_W-1:0]};
            vct_pkg::REG_CTL:
                rd_val = {{(vct_pkg::DATA_W - 3){1'b0}},
                          enable_reg && expired, mask_reg, enable_reg};
            vct_pkg::REG_CVAL:
                rd_val = deadline_reg;
            default:
                rd_val = '0;
        endcase
    end

    always_comb
    begin
        deadline_next = deadline_reg;
        enable_next   = enable_reg;
        mask_next     = mask_reg;
        bdl_next      = bdl_reg;
        barmed_next   = barmed_reg;

        res.handled    = 1'b0;
        res.read_valid = 1'b0;
        res.read_data  = '0;
        res.dest_reg   = dec.fire ? '0 : dec.rt;
        res.irq        = dec.fire;

        if (dec.fire)
        begin
            barmed_next = 1'b0;
        end
        else if (dec.hit)
        begin
            res.handled = 1'b1;
            if (dec.is_read)
            begin
                if (!dec.rt_zr)
                begin
                    res.read_valid = 1'b1;
                    res.read_data  = rd_val;
                end
            end
            else
            begin
                case (dec.reg_sel)
                    vct_pkg::REG_TVAL: deadline_next = count_now + tval_ext;
                    vct_pkg::REG_CTL:
                    begin
                        enable_next = src[0];
                        mask_next   = src[1];
                    end
                    vct_pkg::REG_CVAL: deadline_next = src;
                    default:           deadline_next = deadline_reg;
                endcase
                // reprogram the backing comparator; disarm keeps old deadline
                if (enable_next && !mask_next)
                begin
                    bdl_next    = deadline_next;
                    barmed_next = 1'b1;
                end
                else
                begin
                    barmed_next = 1'b0;
                end
            end
        end

        res.cmp_deadline = bdl_next;
        res.cmp_armed    = barmed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_reg <= '0;
            enable_reg   <= 1'b0;
            mask_reg     <= 1'b0;
            bdl_reg      <= '0;
            barmed_reg   <= 1'b0;
        end
        else if (step)
        begin
            deadline_reg <= deadline_next;
            enable_reg   <= enable_next;
            mask_reg     <= mask_next;
            bdl_reg      <= bdl_next;
            barmed_reg   <= barmed_next;
        end
    end

endmodule

// ===== src/virtual_compare_timer_regs_core.sv =====
// Channel  | Handshake           | Beat contents
// ---------+---------------------+-------------------------------------------
// input    | in_valid / in_ready | kind, syndrome, write_data, count_now
// output   | out_valid/out_ready | handled, read_valid, read_data, dest_reg,
//          |                     | comparator_deadline, comparator_armed,
//          |                     | raise_interrupt
//
// One beat per cycle sustained while the output is not stalled; a beat passes
// the input register, then the result register. The timer state updates as a
// beat moves into the result register, so each beat sees its predecessor's writes.
// A stalled output holds its beat; the input register still takes a beat while
// the result waits, and in_ready drops only when both stages are full.
// Reset clears the timer state and both valid flags.
module virtual_compare_timer_regs_core
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       kind,
    input  logic [vct_pkg::SYN_W-1:0]  syndrome,
    input  logic [vct_pkg::DATA_W-1:0] write_data,
    input  logic [vct_pkg::DATA_W-1:0] count_now,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       handled,
    output logic                       read_valid,
    output logic [vct_pkg::DATA_W-1:0] read_data,
    output logic [4:0]                 dest_reg,
    output logic [vct_pkg::DATA_W-1:0] comparator_deadline,
    output logic                       comparator_armed,
    output logic                       raise_interrupt
);

    // Input register
    logic                       in_valid_reg;
    logic                       kind_reg;
    logic [vct_pkg::SYN_W-1:0]  syndrome_reg;
    logic [vct_pkg::DATA_W-1:0] wdata_reg;
    logic [vct_pkg::DATA_W-1:0] count_reg;

    // Result register
    logic                       out_valid_reg;
    vct_pkg::result_t           res_reg;

    logic                       advance;   // result register can load
    logic                       step;      // a beat moves through execute
    vct_pkg::dec_t              dec;
    vct_pkg::result_t           res;

    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg     <= kind;
            syndrome_reg <= syndrome;
            wdata_reg    <= write_data;
            count_reg    <= count_now;
        end
        if (step)
        begin
            res_reg <= res;
        end
    end

    vct_decode u_decode
    (
        .kind     (kind_reg),
        .syndrome (syndrome_reg),
        .dec      (dec)
    );

    vct_exec u_exec
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .dec        (dec),
        .write_data (wdata_reg),
        .count_now  (count_reg),
        .res        (res)
    );

    assign out_valid           = out_valid_reg;
    assign handled             = res_reg.handled;
    assign read_valid          = res_reg.read_valid;
    assign read_data           = res_reg.read_data;
    assign dest_reg            = res_reg.dest_reg;
    assign comparator_deadline = res_reg.cmp_deadline;
    assign comparator_armed    = res_reg.cmp_armed;
    assign raise_interrupt     = res_reg.irq;

    // A fire beat is never a decoded access and names no register
    a_fire_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && raise_interrupt) |-> (!handled && dest_reg == 5'd0 && !comparator_armed))
        else $error("fire beat carries access results");

    // Read data only on a handled read
    a_read_handled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && read_valid) |-> handled)
        else $error("read_valid without handled access");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !read_valid) |-> (read_data == '0))
        else $error("read_data nonzero without read_valid");

    // Input side stalls only when both stages are full and the output is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low without output stall");

endmodule
